/* src/clnsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_pkg
// Types, codes and constants shared by the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clnsq_pkg;

    // display command codes carried by an input item
    typedef enum logic [1:0] {
        CMD_WRITE_CHAR = 2'd0,
        CMD_CLEAR      = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_INIT       = 2'd3
    } cmd_code_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_COMMAND_WAIT = 2'd0,
        CFG_CLEAR_WAIT   = 2'd1,
        CFG_POWERUP_WAIT = 2'd2
    } cfg_index_t;

    // kind of job handed from the front end to the back end
    typedef enum logic [1:0] {
        JOB_CHAR  = 2'd0,
        JOB_INSTR = 2'd1,
        JOB_CLEAR = 2'd2,
        JOB_INIT  = 2'd3
    } job_kind_t;

    // selects the wait after a strobe
    typedef enum logic [2:0] {
        AFTER_NONE    = 3'd0,
        AFTER_RESET1  = 3'd1,
        AFTER_RESET2  = 3'd2,
        AFTER_COMMAND = 3'd3,
        AFTER_CLEAR   = 3'd4
    } after_sel_t;

    // input item
    typedef struct packed {
        cmd_code_t   command;
        logic [7:0]  value;
    } cmd_item_t;

    // result item, one per enable strobe
    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_before_us;
        logic [15:0] wait_after_us;
        logic        last;
    } xfer_item_t;

    // queue entry between front and back
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data_byte;
    } job_t;

    // configuration register set
    typedef struct packed {
        logic [15:0] command_wait_us;
        logic [15:0] clear_wait_us;
        logic [15:0] powerup_wait_us;
    } cfg_t;

    // one step of the initialization run
    typedef struct packed {
        logic [3:0]  nibble;
        after_sel_t  after_sel;
        logic        powerup_before;
    } init_step_t;

    localparam logic [15:0] COMMAND_WAIT_RESET = 16'd40;
    localparam logic [15:0] CLEAR_WAIT_RESET   = 16'd2000;
    localparam logic [15:0] POWERUP_WAIT_RESET = 16'd15000;
    localparam logic [15:0] RESET_WAIT1_US     = 16'd5000;
    localparam logic [15:0] RESET_WAIT2_US     = 16'd100;
    localparam logic [15:0] WAIT_MAX           = 16'hFFFF;

    localparam logic [7:0]  CLEAR_BYTE    = 8'h01;
    localparam logic [7:0]  SET_DDRAM     = 8'h80;
    localparam logic [7:0]  LINE_TWO_BASE = 8'h40;

    localparam logic [3:0]  BYTE_LAST_STEP = 4'd1;
    localparam logic [3:0]  INIT_LAST_STEP = 4'd11;

    // initialization run: three reset nibbles, 4-bit mode, function set 0x28,
    // display on 0x0C, entry mode 0x06, clear 0x01
    function automatic init_step_t init_step(input logic [3:0] step);
        init_step_t s;
        s = '{nibble: 4'h0, after_sel: AFTER_NONE, powerup_before: 1'b0};
        case (step)
            4'd0:  s = '{nibble: 4'h3, after_sel: AFTER_RESET1,  powerup_before: 1'b1};
            4'd1:  s = '{nibble: 4'h3, after_sel: AFTER_RESET2,  powerup_before: 1'b0};
            4'd2:  s = '{nibble: 4'h3, after_sel: AFTER_COMMAND, powerup_before: 1'b0};
            4'd3:  s = '{nibble: 4'h2, after_sel: AFTER_COMMAND, powerup_before: 1'b0};
            4'd4:  s = '{nibble: 4'h2, after_sel: AFTER_NONE,    powerup_before: 1'b0};
            4'd5:  s = '{nibble: 4'h8, after_sel: AFTER_COMMAND, powerup_before: 1'b0};
            4'd6:  s = '{nibble: 4'h0, after_sel: AFTER_NONE,    powerup_before: 1'b0};
            4'd7:  s = '{nibble: 4'hC, after_sel: AFTER_COMMAND, powerup_before: 1'b0};
            4'd8:  s = '{nibble: 4'h0, after_sel: AFTER_NONE,    powerup_before: 1'b0};
            4'd9:  s = '{nibble: 4'h6, after_sel: AFTER_COMMAND, powerup_before: 1'b0};
            4'd10: s = '{nibble: 4'h0, after_sel: AFTER_NONE,    powerup_before: 1'b0};
            4'd11: s = '{nibble: 4'h1, after_sel: AFTER_CLEAR,   powerup_before: 1'b0};
            default: s = '{nibble: 4'h0, after_sel: AFTER_NONE, powerup_before: 1'b0};
        endcase
        return s;
    endfunction

endpackage

/* src/clnsq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_front
// Accepts command items, maps them to byte jobs and drops out-of-range
// cursor positions.
// ----------------------------------------------------------------------------
module clnsq_front
    import clnsq_pkg::*;
#(
    parameter int LINE_LENGTH = 16
) (
    input  logic      s_valid,
    output logic      s_ready,
    input  cmd_item_t s_data,
    output logic      push_valid,
    input  logic      push_ready,
    output job_t      push_job
);

    localparam logic [7:0] LINE_LEN8 = 8'(LINE_LENGTH);
    localparam logic [7:0] MAX_POS   = 8'(2 * LINE_LENGTH);

    logic [7:0] pos_m1;
    logic [7:0] ddram_addr;
    logic       pos_ok;
    logic       drop;

    // cursor position to display address, line two starts at 0x40
    always_comb begin
        pos_m1     = s_data.value - 8'd1;
        pos_ok     = (s_data.value != 8'd0) && (s_data.value <= MAX_POS);
        ddram_addr = (pos_m1 >= LINE_LEN8) ? (pos_m1 - LINE_LEN8 + LINE_TWO_BASE) : pos_m1;
    end

    // classify the item into a job
    always_comb begin
        drop     = 1'b0;
        push_job = '{kind: JOB_CHAR, data_byte: s_data.value};
        unique case (s_data.command)
            CMD_WRITE_CHAR: push_job = '{kind: JOB_CHAR, data_byte: s_data.value};
            CMD_CLEAR:      push_job = '{kind: JOB_CLEAR, data_byte: CLEAR_BYTE};
            CMD_SET_CURSOR: begin
                push_job = '{kind: JOB_INSTR, data_byte: ddram_addr | SET_DDRAM};
                drop     = !pos_ok;
            end
            CMD_INIT:       push_job = '{kind: JOB_INIT, data_byte: CLEAR_BYTE};
            default:        push_job = '{kind: JOB_CHAR, data_byte: s_data.value};
        endcase
    end

    // an item that makes no transfers is taken and not queued
    assign s_ready    = push_ready;
    assign push_valid = s_valid && !drop;

endmodule

/* src/clnsq_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_queue
// Short job queue between front end and back end.
// ----------------------------------------------------------------------------
module clnsq_queue
    import clnsq_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/clnsq_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_back
// Steps through the nibble transfers of the job at the queue head and holds
// each transfer in the output register.
// ----------------------------------------------------------------------------
module clnsq_back
    import clnsq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output xfer_item_t m_data
);

    logic [3:0] step_reg, step_next;
    logic       m_valid_reg, m_valid_next;
    xfer_item_t m_data_reg;

    logic       out_free;
    logic       load;
    logic       is_init;
    logic       is_last;
    logic [16:0] clear_sum;
    logic [15:0] clear_after;
    init_step_t init_s;
    after_sel_t after_sel;
    xfer_item_t xfer;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free && job_valid;
    assign is_init  = (job.kind == JOB_INIT);
    assign is_last  = is_init ? (step_reg == INIT_LAST_STEP) : (step_reg == BYTE_LAST_STEP);
    assign job_pop  = load && is_last;

    // clear wait, saturated
    assign clear_sum   = {1'b0, cfg.command_wait_us} + {1'b0, cfg.clear_wait_us};
    assign clear_after = clear_sum[16] ? WAIT_MAX : clear_sum[15:0];

    // build the transfer for the current step
    always_comb begin
        init_s    = init_step(step_reg);
        after_sel = AFTER_NONE;
        xfer      = '0;
        if (is_init) begin
            xfer.reg_select     = 1'b0;
            xfer.nibble         = init_s.nibble;
            xfer.wait_before_us = init_s.powerup_before ? cfg.powerup_wait_us : 16'd0;
            after_sel           = init_s.after_sel;
        end else begin
            xfer.reg_select     = (job.kind == JOB_CHAR);
            xfer.nibble         = step_reg[0] ? job.data_byte[3:0] : job.data_byte[7:4];
            xfer.wait_before_us = 16'd0;
            if (step_reg[0]) begin
                after_sel = (job.kind == JOB_CLEAR) ? AFTER_CLEAR : AFTER_COMMAND;
            end
        end
        unique case (after_sel)
            AFTER_NONE:    xfer.wait_after_us = 16'd0;
            AFTER_RESET1:  xfer.wait_after_us = RESET_WAIT1_US;
            AFTER_RESET2:  xfer.wait_after_us = RESET_WAIT2_US;
            AFTER_COMMAND: xfer.wait_after_us = cfg.command_wait_us;
            AFTER_CLEAR:   xfer.wait_after_us = clear_after;
            default:       xfer.wait_after_us = 16'd0;
        endcase
        xfer.last = is_last;
    end

    // step counter and output register control
    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = job_valid;
        end
        if (load) begin
            step_next = is_last ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= xfer;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // step count stays within the longest run
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= INIT_LAST_STEP)
        else $error("step counter past end of init run");

    // a partly sent job stays at the queue head
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 4'd0) |-> job_valid)
        else $error("job left queue before its last transfer");

    // byte jobs take two steps only
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && !is_init) |-> (step_reg <= BYTE_LAST_STEP))
        else $error("byte job past its second nibble");

    // after the last transfer of a job the step count restarts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && is_last) |=> (step_reg == 4'd0))
        else $error("step counter not cleared after last transfer");

    // a wait before the strobe only on the first init nibble
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && xfer.wait_before_us != 16'd0) |-> (is_init && step_reg == 4'd0))
        else $error("wait before strobe outside first init nibble");
`endif

endmodule

/* src/char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns display commands into 4-bit transfers for a character LCD.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one command item (write char, clear, set cursor, init).
//   m_ channel gives one nibble transfer per item: register select, data
//   nibble (high nibble first), wait before and after the strobe, and last
//   on the final transfer of the command.
//   cfg channel writes the three wait registers (index 0 command wait,
//   1 clear wait, 2 power-up wait); it is always ready and is meant to be
//   used only while no command is in flight. Other indexes are ignored.
// Throughput:
//   an item is written into the job queue, and its first transfer is then
//   loaded into the output register, from which it is valid on m_.
//   While m_ready is high the output stage gives one transfer per cycle; a
//   byte command gives 2 transfers, initialize gives 12, and a cursor
//   position out of range gives none. A four-entry job queue lets new
//   commands be taken while earlier ones are still being sent.
// Reset and stall:
//   reset empties the queue and output stage and restores the wait
//   registers (40, 2000, 15000 us). When m_ready is low the current transfer
//   holds; the queue fills and then s_ready drops.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer
    import clnsq_pkg::*;
#(
    parameter int LINE_LENGTH = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cmd_item_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output xfer_item_t  m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic job_valid;
    logic job_pop;
    job_t job_head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COMMAND_WAIT: cfg_next.command_wait_us = cfg_data;
                CFG_CLEAR_WAIT:   cfg_next.clear_wait_us   = cfg_data;
                CFG_POWERUP_WAIT: cfg_next.powerup_wait_us = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_wait_us <= COMMAND_WAIT_RESET;
            cfg_reg.clear_wait_us   <= CLEAR_WAIT_RESET;
            cfg_reg.powerup_wait_us <= POWERUP_WAIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // command classification
    clnsq_front #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // job queue
    clnsq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_job),
        .rd_valid (job_valid),
        .rd_ready (job_pop),
        .rd_data  (job_head)
    );

    // transfer sequencing
    clnsq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
